// ===== rtl/skht_pkg.sv =====
// Package for the string-key hash table: sizes, codes, slot layout and mask helpers.
`default_nettype none
package skht_pkg;

  localparam int SLOTS      = 256;
  localparam int KEY_BYTES  = 8;
  localparam int DATA_BYTES = 4;

  localparam int IDX_W      = $clog2(SLOTS);
  localparam int CNT_W      = IDX_W + 1;
  localparam int KEY_W      = 64;
  localparam int KLEN_W     = 4;
  localparam int DATA_W     = 32;
  localparam int DLEN_W     = 3;
  localparam int LOAD_LIMIT = 3 * SLOTS / 4;

  localparam logic [31:0] FNV_BASIS = 32'h811C_9DC5;
  localparam logic [31:0] FNV_PRIME = 32'h0100_0193;

  typedef enum logic [1:0] {
    MODE_INSERT  = 2'd0,
    MODE_REPLACE = 2'd1,
    MODE_FIND    = 2'd2,
    MODE_SPARE   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_EXISTS    = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_FULL      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_HASH,
    S_PROBE,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [KLEN_W-1:0] klen;
    logic [DATA_W-1:0] data;
    logic [DLEN_W-1:0] dlen;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  function automatic logic [KLEN_W-1:0] sat_klen(input logic [KLEN_W-1:0] n);
    logic [KLEN_W-1:0] r;
    r = n;
    if (n > KLEN_W'(KEY_BYTES)) r = KLEN_W'(KEY_BYTES);
    return r;
  endfunction

  function automatic logic [DLEN_W-1:0] sat_dlen(input logic [DLEN_W-1:0] n);
    logic [DLEN_W-1:0] r;
    r = n;
    if (n > DLEN_W'(DATA_BYTES)) r = DLEN_W'(DATA_BYTES);
    return r;
  endfunction

  function automatic logic [KEY_W-1:0] key_mask(input logic [KLEN_W-1:0] n);
    logic [KEY_W-1:0] m;
    m = '0;
    for (int b = 0; b < KEY_W / 8; b++) begin
      if (KLEN_W'(b) < n) m[8*b +: 8] = 8'hFF;
    end
    return m;
  endfunction

  function automatic logic [DATA_W-1:0] data_mask(input logic [DLEN_W-1:0] n);
    logic [DATA_W-1:0] m;
    m = '0;
    for (int b = 0; b < DATA_W / 8; b++) begin
      if (DLEN_W'(b) < n) m[8*b +: 8] = 8'hFF;
    end
    return m;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/skht_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module skht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// ===== rtl/skht_hash.sv =====
// Byte-serial FNV-1a hash unit: one key byte per cycle through one multiplier.
`default_nettype none
module skht_hash (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [skht_pkg::KEY_W-1:0]  key,
  input  wire logic [skht_pkg::KLEN_W-1:0] len,
  output logic                            done,
  output logic      [31:0]                hash
);
  import skht_pkg::*;

  logic              busy;
  logic [KLEN_W-1:0] cnt;
  logic [KEY_W-1:0]  sh;
  logic [31:0]       mix;

  assign mix  = hash ^ {24'd0, sh[7:0]};
  assign done = busy && (cnt == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= len;
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt - KLEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      hash <= FNV_BASIS;
      sh   <= key;
    end else if (busy && cnt != '0) begin
      hash <= mix * FNV_PRIME;
      sh   <= {8'd0, sh[KEY_W-1:8]};
    end
  end

endmodule
`default_nettype wire

// ===== rtl/string_key_hash_table_top.sv =====
// Top level of the string-key hash table: request sequencer, probe logic and slot storage.
//
// Open-addressing table of 256 slots keyed by strings of up to 8 bytes, with
// 4 data bytes per slot. One request is worked at a time; in_ready is high
// only while the block is idle. A request is accepted, then hashed by the
// byte-serial FNV-1a hash unit (one 32x32 multiply per key byte), then
// probed with one slot RAM read per cycle, and its result is loaded into
// the result register once the output side is free. An insert refused as
// table full by the load check skips hashing and probing and goes straight
// to the result register. The used marks are flip-flops cleared by reset,
// so no clearing pass follows reset. The load bound keeps probe chains short.
`default_nettype none
module string_key_hash_table_top (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [1:0]                  mode,
  input  wire logic [skht_pkg::KEY_W-1:0]  key_bytes,
  input  wire logic [skht_pkg::KLEN_W-1:0] key_length,
  input  wire logic [skht_pkg::DATA_W-1:0] data_in,
  input  wire logic [skht_pkg::DLEN_W-1:0] data_length,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic      [1:0]                  status,
  output logic      [skht_pkg::DATA_W-1:0] data_out,
  output logic      [skht_pkg::DLEN_W-1:0] data_out_length
);
  import skht_pkg::*;

  state_t            state, state_next;
  mode_t             req_mode;
  logic [KEY_W-1:0]  req_key;
  logic [KLEN_W-1:0] req_klen;
  logic [DATA_W-1:0] req_data;
  logic [DLEN_W-1:0] req_dlen;
  logic [IDX_W-1:0]  idx, idx_next;
  logic [IDX_W-1:0]  probes, probes_next;
  logic [CNT_W-1:0]  count;
  logic [SLOTS-1:0]  used;
  status_t           res_status, res_status_next;
  logic [DATA_W-1:0] res_data, res_data_next;
  logic [DLEN_W-1:0] res_dlen, res_dlen_next;

  logic [KLEN_W-1:0] in_klen;
  logic [DLEN_W-1:0] in_dlen;
  logic [KEY_W-1:0]  in_key;
  logic [DATA_W-1:0] in_data;
  logic              accept, table_full, hash_start, hash_done;
  logic [31:0]       hash;
  logic              wr_en, used_set, out_load;
  slot_t             wr_slot, rd_slot;
  logic [SLOT_W-1:0] rd_word;
  logic [DLEN_W-1:0] min_dlen;

  assign in_klen    = sat_klen(key_length);
  assign in_dlen    = sat_dlen(data_length);
  assign in_key     = key_bytes & key_mask(in_klen);
  assign in_data    = data_in & data_mask(in_dlen);
  assign in_ready   = (state == S_IDLE);
  assign accept     = in_valid && in_ready;
  assign table_full = ((CNT_W+1)'(count) + (CNT_W+1)'(2)) > (CNT_W+1)'(LOAD_LIMIT);
  assign hash_start = accept && !(mode_t'(mode) == MODE_INSERT && table_full);

  assign wr_slot = '{key: req_key, klen: req_klen, data: req_data, dlen: req_dlen};
  assign rd_slot = slot_t'(rd_word);
  assign min_dlen = (req_dlen < rd_slot.dlen) ? req_dlen : rd_slot.dlen;

  skht_hash u_hash (
    .clk  (clk),
    .rst  (rst),
    .start(hash_start),
    .key  (in_key),
    .len  (in_klen),
    .done (hash_done),
    .hash (hash)
  );

  skht_ram #(
    .WIDTH(SLOT_W),
    .DEPTH(SLOTS)
  ) u_slots (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(idx),
    .wr_data(wr_slot),
    .rd_addr(idx_next),
    .rd_data(rd_word)
  );

  always_comb begin
    state_next      = state;
    idx_next        = idx;
    probes_next     = probes;
    res_status_next = res_status;
    res_data_next   = res_data;
    res_dlen_next   = res_dlen;
    wr_en           = 1'b0;
    used_set        = 1'b0;
    out_load        = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          res_status_next = STAT_OK;
          res_data_next   = '0;
          res_dlen_next   = '0;
          if (hash_start) begin
            state_next = S_HASH;
          end else begin
            res_status_next = STAT_FULL;
            state_next      = S_RESP;
          end
        end
      end
      S_HASH: begin
        if (hash_done) begin
          idx_next    = hash[IDX_W-1:0];
          probes_next = '0;
          state_next  = S_PROBE;
        end
      end
      S_PROBE: begin
        if (!used[idx]) begin
          state_next = S_RESP;
          if (req_mode == MODE_INSERT) begin
            wr_en    = 1'b1;
            used_set = 1'b1;
          end else begin
            res_status_next = STAT_NOT_FOUND;
          end
        end else if (rd_slot.klen == req_klen && rd_slot.key == req_key) begin
          state_next = S_RESP;
          case (req_mode)
            MODE_INSERT:  res_status_next = STAT_EXISTS;
            MODE_REPLACE: wr_en = 1'b1;
            default: begin
              res_dlen_next = min_dlen;
              res_data_next = rd_slot.data & data_mask(min_dlen);
            end
          endcase
        end else if (probes == '1) begin
          state_next      = S_RESP;
          res_status_next = (req_mode == MODE_INSERT) ? STAT_FULL : STAT_NOT_FOUND;
        end else begin
          idx_next    = idx + IDX_W'(1);
          probes_next = probes + IDX_W'(1);
        end
      end
      S_RESP: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      used      <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (used_set) begin
        used[idx] <= 1'b1;
        count     <= count + CNT_W'(1);
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx        <= idx_next;
    probes     <= probes_next;
    res_status <= res_status_next;
    res_data   <= res_data_next;
    res_dlen   <= res_dlen_next;
    if (accept) begin
      req_mode <= mode_t'(mode);
      req_key  <= in_key;
      req_klen <= in_klen;
      req_data <= in_data;
      req_dlen <= in_dlen;
    end
    if (out_load) begin
      status          <= res_status;
      data_out        <= res_data;
      data_out_length <= res_dlen;
    end
  end

endmodule
`default_nettype wire

// ===== bench/string_key_hash_table_top_test.sv =====
// Testbench for string_key_hash_table_top: request driver, shadow table model and reply checker.
module string_key_hash_table_top_test;
  import skht_pkg::*;

  typedef struct {
    mode_t       mode;
    logic [63:0] key;
    logic [3:0]  klen;
    logic [31:0] data;
    logic [2:0]  dlen;
  } request_t;

  typedef struct {
    status_t     status;
    logic [31:0] data;
    logic [2:0]  dlen;
  } reply_t;

  typedef struct {
    logic [63:0] key;
    int          len;
  } stored_key_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic [1:0]  mode = 2'd0;
  logic [63:0] key_bytes = 64'd0;
  logic [3:0]  key_length = 4'd0;
  logic [31:0] data_in = 32'd0;
  logic [2:0]  data_length = 3'd0;
  logic        out_ready = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic [1:0]  status;
  logic [31:0] data_out;
  logic [2:0]  data_out_length;

  request_t    requests_to_send[$];
  reply_t      replies_due[$];
  stored_key_t key_pool[$];

  bit          shadow_used[SLOTS];
  logic [63:0] shadow_key[SLOTS];
  int          shadow_klen[SLOTS];
  logic [31:0] shadow_data[SLOTS];
  int          shadow_dlen[SLOTS];
  int          shadow_count = 0;

  int          fail_count = 0;
  int          burst_left = 0;
  int          gap_left = 0;
  int          ready_style = 0;
  int          ready_left = 0;
  int          ready_tick = 0;

  string_key_hash_table_top u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .mode(mode),
    .key_bytes(key_bytes),
    .key_length(key_length),
    .data_in(data_in),
    .data_length(data_length),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .data_out(data_out),
    .data_out_length(data_out_length)
  );

  always #1 clk = ~clk;

  function automatic logic [63:0] byte_mask(int n);
    if (n >= 8) return '1;
    return (64'd1 << (8 * n)) - 64'd1;
  endfunction

  function automatic request_t make_req(mode_t m, logic [63:0] k, logic [3:0] kl,
                                        logic [31:0] d, logic [2:0] dl);
    request_t r;
    r.mode = m;
    r.key  = k;
    r.klen = kl;
    r.data = d;
    r.dlen = dl;
    return r;
  endfunction

  function automatic logic [31:0] fnv1a_hash(logic [63:0] k, int len);
    logic [31:0] h;
    h = FNV_BASIS;
    for (int i = 0; i < len; i++) begin
      h = h ^ {24'd0, k[8*i +: 8]};
      h = h * FNV_PRIME;
    end
    return h;
  endfunction

  // home slot, then linear probe until empty or matching key
  function automatic int locate_slot(logic [63:0] k, int len);
    int idx;
    idx = int'(fnv1a_hash(k, len) & 32'(SLOTS - 1));
    for (int n = 0; n < SLOTS; n++) begin
      if (!shadow_used[idx]) return idx;
      if (shadow_klen[idx] == len && shadow_key[idx] == k) return idx;
      idx = (idx + 1) % SLOTS;
    end
    return SLOTS;
  endfunction

  function automatic reply_t apply_to_shadow_table(request_t r);
    reply_t      a;
    int          klen;
    int          dlen;
    int          slot;
    int          n;
    logic [63:0] k;
    logic [63:0] m;
    logic [31:0] d;
    a.status = STAT_OK;
    a.data   = '0;
    a.dlen   = '0;
    klen = (int'(r.klen) > KEY_BYTES) ? KEY_BYTES : int'(r.klen);
    dlen = (int'(r.dlen) > DATA_BYTES) ? DATA_BYTES : int'(r.dlen);
    k = r.key & byte_mask(klen);
    m = byte_mask(dlen);
    d = r.data & m[31:0];
    case (r.mode)
      MODE_INSERT: begin
        if (4 * (shadow_count + 2) > 3 * SLOTS) begin
          a.status = STAT_FULL;
        end else begin
          slot = locate_slot(k, klen);
          if (slot >= SLOTS) begin
            a.status = STAT_FULL;
          end else if (shadow_used[slot]) begin
            a.status = STAT_EXISTS;
          end else begin
            shadow_used[slot] = 1'b1;
            shadow_key[slot]  = k;
            shadow_klen[slot] = klen;
            shadow_data[slot] = d;
            shadow_dlen[slot] = dlen;
            shadow_count++;
          end
        end
      end
      MODE_REPLACE: begin
        slot = locate_slot(k, klen);
        if (slot < SLOTS && shadow_used[slot]) begin
          shadow_data[slot] = d;
          shadow_dlen[slot] = dlen;
        end else begin
          a.status = STAT_NOT_FOUND;
        end
      end
      default: begin
        slot = locate_slot(k, klen);
        if (slot < SLOTS && shadow_used[slot]) begin
          n = (dlen < shadow_dlen[slot]) ? dlen : shadow_dlen[slot];
          m = byte_mask(n);
          a.dlen = 3'(n);
          a.data = shadow_data[slot] & m[31:0];
        end else begin
          a.status = STAT_NOT_FOUND;
        end
      end
    endcase
    return a;
  endfunction

  initial begin : stimulus
    request_t    r;
    stored_key_t ke;
    int          roll;
    int          kl;
    logic [63:0] stray;
    // empty table, empty key, zero bytes as key content, over-long key and data lengths, spare mode
    requests_to_send.push_back(make_req(MODE_FIND, 64'h0, 4'd0, 32'h0, 3'd4));
    requests_to_send.push_back(make_req(MODE_REPLACE, 64'h0, 4'd0, 32'h1234, 3'd2));
    requests_to_send.push_back(make_req(MODE_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0,
                                        32'hFFFF_FFFF, 3'd0));
    requests_to_send.push_back(make_req(MODE_INSERT, 64'h0, 4'd0, 32'h55, 3'd1));
    requests_to_send.push_back(make_req(MODE_FIND, 64'h0, 4'd0, 32'h0, 3'd4));
    requests_to_send.push_back(make_req(MODE_INSERT, 64'h0, 4'd1, 32'hFFFF_FFFF, 3'd4));
    requests_to_send.push_back(make_req(MODE_INSERT, 64'hFFFF_FFFF_FFFF_0000, 4'd2,
                                        32'hFFFF_FFFF, 3'd7));
    requests_to_send.push_back(make_req(MODE_FIND, 64'hFFFF_FFFF_FFFF_FF00, 4'd1,
                                        32'h0, 3'd7));
    requests_to_send.push_back(make_req(MODE_FIND, 64'h0, 4'd2, 32'hFFFF_FFFF, 3'd2));
    requests_to_send.push_back(make_req(MODE_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15,
                                        32'hA5A5_A5A5, 3'd3));
    requests_to_send.push_back(make_req(MODE_FIND, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8,
                                        32'h0, 3'd4));
    requests_to_send.push_back(make_req(MODE_FIND, 64'hFFFF_FFFF_FFFF_FFFF, 4'd12,
                                        32'h0, 3'd5));
    requests_to_send.push_back(make_req(MODE_REPLACE, 64'hFFFF_FFFF_FFFF_FFFF, 4'd9,
                                        32'h1234_5678, 3'd2));
    requests_to_send.push_back(make_req(MODE_SPARE, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8,
                                        32'h0, 3'd4));
    requests_to_send.push_back(make_req(MODE_FIND, 64'hFFFF_FFFF_FFFF_FFFF, 4'd7,
                                        32'h0, 3'd4));
    requests_to_send.push_back(make_req(MODE_REPLACE, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0,
                                        32'hDEAD_BEEF, 3'd6));
    requests_to_send.push_back(make_req(MODE_FIND, 64'h0, 4'd0, 32'h0, 3'd1));
    requests_to_send.push_back(make_req(MODE_INSERT, 64'h0123_4567_89AB_CDEF, 4'd8,
                                        32'h8000_0001, 3'd1));
    requests_to_send.push_back(make_req(MODE_FIND, 64'h0123_4567_89AB_CDEF, 4'd8,
                                        32'hFFFF_FFFF, 3'd0));
    requests_to_send.push_back(make_req(MODE_SPARE, 64'h0000_0000_0000_0061, 4'd1,
                                        32'h0, 3'd4));
    requests_to_send.push_back(make_req(MODE_INSERT, 64'h0000_0000_0000_0061, 4'd1,
                                        32'h0102_0304, 3'd4));
    requests_to_send.push_back(make_req(MODE_REPLACE, 64'h0, 4'd1, 32'h0, 3'd0));
    requests_to_send.push_back(make_req(MODE_FIND, 64'h0, 4'd1, 32'h0, 3'd4));

    // mostly well-formed traffic on known keys, enough inserts to hit the load limit
    for (int i = 0; i < 700; i++) begin
      roll   = $urandom_range(0, 99);
      r.data = $urandom;
      r.dlen = 3'($urandom_range(0, 7));
      if (roll < 50) r.mode = MODE_INSERT;
      else if (roll < 70) r.mode = MODE_REPLACE;
      else if (roll < 95) r.mode = MODE_FIND;
      else r.mode = MODE_SPARE;
      if (key_pool.size() == 0 || (r.mode == MODE_INSERT && $urandom_range(0, 3) != 0) ||
          $urandom_range(0, 9) == 0) begin
        kl = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
        for (int b = 0; b < 8; b++) begin
          r.key[8*b +: 8] = ($urandom_range(0, 4) == 0) ? 8'h00 : 8'($urandom);
        end
        r.klen = 4'(kl);
        if (r.mode == MODE_INSERT) begin
          ke.len = (kl > 8) ? 8 : kl;
          ke.key = r.key & byte_mask(ke.len);
          key_pool.push_back(ke);
        end
      end else begin
        ke     = key_pool[$urandom_range(0, key_pool.size() - 1)];
        stray  = {$urandom, $urandom};
        r.key  = ke.key | (stray & ~byte_mask(ke.len));
        r.klen = 4'(ke.len);
        if (ke.len == 8 && $urandom_range(0, 1) == 1) begin
          r.klen = 4'($urandom_range(9, 15));
        end else if ($urandom_range(0, 19) == 0) begin
          r.klen = (ke.len == 0) ? 4'd1 : 4'(ke.len - 1);
        end
      end
      requests_to_send.push_back(r);
    end
  end

  always @(posedge clk) begin : drive_requests
    request_t r;
    if (!rst) begin
      if (in_valid && in_ready) begin
        replies_due.push_back(apply_to_shadow_table(
          make_req(mode_t'(mode), key_bytes, key_length, data_in, data_length)));
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (requests_to_send.size() > 0) begin
          r = requests_to_send.pop_front();
          mode        <= r.mode;
          key_bytes   <= r.key;
          key_length  <= r.klen;
          data_in     <= r.data;
          data_length <= r.dlen;
          in_valid    <= 1'b1;
          if (burst_left > 1) begin
            burst_left <= burst_left - 1;
          end else if ($urandom_range(0, 7) == 0) begin
            burst_left <= $urandom_range(30, 80);
            gap_left   <= 0;
          end else begin
            burst_left <= $urandom_range(1, 12);
            gap_left   <= ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 20);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_replies
    reply_t due;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (replies_due.size() == 0) begin
          $display("%0t unexpected reply: expected none, got status %0d data %h len %0d",
                   $time, status, data_out, data_out_length);
          fail_count++;
        end else begin
          due = replies_due.pop_front();
          if (status !== due.status) begin
            $display("%0t status mismatch: expected %0d, got %0d", $time, due.status, status);
            fail_count++;
          end
          if (data_out !== due.data) begin
            $display("%0t data_out mismatch: expected %h, got %h", $time, due.data, data_out);
            fail_count++;
          end
          if (data_out_length !== due.dlen) begin
            $display("%0t data_out_length mismatch: expected %0d, got %0d",
                     $time, due.dlen, data_out_length);
            fail_count++;
          end
        end
      end
      ready_tick <= ready_tick + 1;
      if (ready_left == 0) begin
        ready_style <= $urandom_range(0, 3);
        ready_left  <= $urandom_range(20, 150);
      end else begin
        ready_left <= ready_left - 1;
      end
      case (ready_style)
        0:       out_ready <= 1'b1;
        1:       out_ready <= 1'($urandom_range(0, 1));
        2:       out_ready <= (ready_tick % 4 == 0);
        default: out_ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    while (requests_to_send.size() > 0 || in_valid || replies_due.size() > 0) begin
      @(negedge clk);
    end
    repeat (50) @(negedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/skht_pkg.sv
rtl/skht_ram.sv
rtl/skht_hash.sv
rtl/string_key_hash_table_top.sv
bench/string_key_hash_table_top_test.sv
